/* rtl/swmm_pkg.sv */
// Shared types and constants for the sliding window min/max/mean block.
// No dependencies; every other file takes names from here by scope.
package swmm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COUNT_W    = 6;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_START,
      ST_DIV,
      ST_HOLD
   } state_type;

   // handshake between the sequencer and the divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
   } div_stat_type;

endpackage

/* rtl/swmm_cell.sv */
// One storage cell of the sample chain: holds one sample, passes it on when shifted.
// Depends on swmm_pkg.
module swmm_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  swmm_pkg::sample_type data_in,
   output swmm_pkg::sample_type data_out
);

   swmm_pkg::sample_type data_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

/* rtl/swmm_div.sv */
// Restoring divider, one quotient bit per cycle: signed sum over unsigned count,
// truncated toward zero. Depends on swmm_pkg.
module swmm_div #(
   parameter int SUM_W = 22,
   parameter int CNT_W = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  swmm_pkg::div_ctrl_type    ctrl,
   input  logic signed [SUM_W-1:0]   dividend,
   input  logic [CNT_W-1:0]          divisor,
   output swmm_pkg::div_stat_type    stat,
   output swmm_pkg::sample_type      quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  mag_ff, mag_in;      // dividend magnitude, becomes quotient
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;

   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    diff;
   logic              fits;
   logic [SUM_W-1:0]  signed_q;

   always_comb begin
      rem_sh  = {rem_ff, mag_ff[SUM_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      fits    = (rem_sh >= {1'b0, dvs_ff});
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         neg_in  = dividend[SUM_W-1];
         mag_in  = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(SUM_W);
      end else if (step_ff != '0) begin
         rem_in  = fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         mag_in  = {mag_ff[SUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign signed_q  = neg_ff ? (SUM_W'(0) - mag_ff) : mag_ff;
   assign quotient  = signed_q[swmm_pkg::SAMPLE_W-1:0];
   assign stat.done = done_ff;

endmodule

/* rtl/sliding_window_min_max_mean.sv */
// Sliding window min/max/mean: top level with the cell chain, scan sequencer,
// accumulators and output register. Depends on swmm_pkg, swmm_cell, swmm_div.
//
// Use:
//   req_* carries one signed 16-bit temperature sample per item (0.01 C units).
//   rsp_* returns one item per sample: min, max and truncated mean of the last
//   WINDOW samples, plus how many are held (saturating at WINDOW, reported
//   modulo 64).
// Sequence:
//   An accepted sample is shifted into the head of a chain of WINDOW cells;
//   the oldest falls off the tail once the chain is full. The chain is then
//   rotated once around while the tail value, when it is a held sample,
//   feeds the min, max and sum accumulators. A one-bit-per-cycle divider
//   then divides the sum by the held count, and the result is loaded into
//   the output register that drives rsp_tvalid. One item is in work at a
//   time: the sequencer returns to idle before it accepts the next sample.
//   For the default WINDOW the rotation of the chain takes most of the time.
// Reset: clears the fill count, sequencer and output valid; the cells hold
//   garbage but only filled cells are ever summed.
// Stall: a finished result waits in the output register; the next sample is
//   accepted and worked on meanwhile, and a second result waits in the
//   divider and accumulators until the output register frees up.
module sliding_window_min_max_mean #(
   parameter int WINDOW = 60
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [swmm_pkg::REQ_DATA_W-1:0] req_tdata,   // [15:0] sample
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] window_min, [31:16] window_max, [47:32] window_mean,
   // [53:48] held_count, [55:54] zero
   output logic [swmm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W  = swmm_pkg::SAMPLE_W + FILL_W;
   localparam int CMP_W  = FILL_W + 1;

   swmm_pkg::state_type state_ff, state_in;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0]  step_ff, step_in;
   swmm_pkg::sample_type lo_ff, lo_in, hi_ff, hi_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [swmm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic shift_en, rotate, load_out, acc_en, take;
   swmm_pkg::div_ctrl_type div_ctrl;
   swmm_pkg::div_stat_type div_stat;
   swmm_pkg::sample_type   quotient;
   swmm_pkg::sample_type   tail;
   swmm_pkg::sample_type   chain [WINDOW];

   // chain of cells; head takes a new sample or the tail value when rotating
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      swmm_pkg::sample_type cell_in;
      if (i == 0) begin : g_head
         assign cell_in = rotate ? tail : swmm_pkg::sample_type'(req_tdata);
      end else begin : g_body
         assign cell_in = chain[i-1];
      end
      swmm_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .data_in  (cell_in),
         .data_out (chain[i])
      );
   end

   assign tail = chain[WINDOW-1];

   swmm_div #(
      .SUM_W (SUM_W),
      .CNT_W (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // output register is free if empty or being drained this cycle
   assign take = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      step_in        = step_ff;
      shift_en       = 1'b0;
      rotate         = 1'b0;
      load_out       = 1'b0;
      div_ctrl.start = 1'b0;
      req_tready     = 1'b0;
      case (state_ff)
         swmm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               shift_en = 1'b1;
               step_in  = '0;
               if (fill_ff != FILL_W'(WINDOW)) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               state_in = swmm_pkg::ST_SCAN;
            end
         end
         swmm_pkg::ST_SCAN: begin
            shift_en = 1'b1;
            rotate   = 1'b1;
            step_in  = step_ff + POS_W'(1);
            if (step_ff == POS_W'(WINDOW - 1)) begin
               state_in = swmm_pkg::ST_START;
            end
         end
         swmm_pkg::ST_START: begin
            div_ctrl.start = 1'b1;
            state_in       = swmm_pkg::ST_DIV;
         end
         swmm_pkg::ST_DIV: begin
            if (div_stat.done) begin
               if (take) begin
                  load_out = 1'b1;
                  state_in = swmm_pkg::ST_IDLE;
               end else begin
                  state_in = swmm_pkg::ST_HOLD;
               end
            end
         end
         swmm_pkg::ST_HOLD: begin
            if (take) begin
               load_out = 1'b1;
               state_in = swmm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swmm_pkg::ST_IDLE;
         end
      endcase
   end

   // at scan step k the tail holds what sat in cell WINDOW-1-k after insert;
   // it is a held sample when k + fill >= WINDOW
   assign acc_en = rotate &&
      ((CMP_W'(step_ff) + CMP_W'(fill_ff)) >= CMP_W'(WINDOW));

   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      sum_in = sum_ff;
      if (state_ff == swmm_pkg::ST_IDLE) begin
         lo_in  = {1'b0, {(swmm_pkg::SAMPLE_W-1){1'b1}}};
         hi_in  = {1'b1, {(swmm_pkg::SAMPLE_W-1){1'b0}}};
         sum_in = '0;
      end else if (acc_en) begin
         if (tail < lo_ff) lo_in = tail;
         if (tail > hi_ff) hi_in = tail;
         sum_in = sum_ff + SUM_W'(tail);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, swmm_pkg::COUNT_W'(fill_ff), quotient, hi_ff, lo_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swmm_pkg::ST_IDLE;
         fill_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/swmm_checker.sv */
// Port-level checks for the sliding window block, attached by bind.
// Depends on swmm_pkg and the top level's port list.
module swmm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [swmm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic signed [swmm_pkg::SAMPLE_W-1:0] mn, mx, mean;

   assign mn   = rsp_tdata[15:0];
   assign mx   = rsp_tdata[31:16];
   assign mean = rsp_tdata[47:32];

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> mn <= mx)
      else $error("window min above max");

   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mean >= mn) && (mean <= mx))
      else $error("window mean outside min/max");

   // one item in work at a time: no accept right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while previous item still in work");

endmodule

bind sliding_window_min_max_mean swmm_checker u_swmm_checker (.*);
